FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the depth pixel back-projection block.
// Each macro samples on clk and is switched off while arst_n is low.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define AST_IMP(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/dpw_pkg.sv
// Package of the depth pixel back-projection block: widths, stream layout,
// register codes and reset values, and the stage-advance struct. No dependencies.
package dpw_pkg;

	// pixel coordinates are taken modulo 2^COORD_W
	localparam int COORD_W = 12;

	localparam int DEPTH_W = 16;
	localparam int COLOR_W = 8;
	localparam int CX_W    = 16;
	localparam int IF_W    = 24;
	localparam int COEF_W  = 18;
	localparam int ROW_W   = 3 * COEF_W;
	localparam int TRANS_W = 21;
	localparam int TR_W    = 3 * TRANS_W;
	localparam int OUT_W   = 28;
	localparam int CFG_W   = TR_W;
	localparam int IDX_W   = 3;

	// datapath widths
	localparam int UX_W   = COORD_W + 4;
	localparam int DU_W   = ((UX_W > CX_W) ? UX_W : CX_W) + 1;
	localparam int DUD_W  = DU_W + DEPTH_W + 1;
	localparam int PRJ_W  = DUD_W + IF_W + 1;
	localparam int CAM_W  = PRJ_W - 24;
	localparam int PROD_W = COEF_W + CAM_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int WIDE_W = ACC_W - 16 + 1;

	localparam logic signed [PRJ_W-1:0] RND24 = PRJ_W'(1) << 23;
	localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(1) << 15;
	localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [WIDE_W-1:0] OUT_MIN = -(WIDE_W'(64'sd1 <<< (OUT_W - 1)));

	// stream layout
	localparam int IN_COL_LO   = DEPTH_W;
	localparam int IN_ROW_LO   = IN_COL_LO + COORD_W;
	localparam int IN_CLR_LO   = IN_ROW_LO + COORD_W;
	localparam int IN_BITS     = IN_CLR_LO + 3 * COLOR_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 3 * OUT_W + 3 * COLOR_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_INV_FOCAL_X = 3'd2,
		REG_INV_FOCAL_Y = 3'd3,
		REG_ROT_ROW0    = 3'd4,
		REG_ROT_ROW1    = 3'd5,
		REG_ROT_ROW2    = 3'd6,
		REG_TRANSLATION = 3'd7
	} dpw_reg_t;

	// reset values: principal point 325.5/253.5, focal 518/519, identity pose
	localparam logic [CX_W-1:0]  RST_CENTER_X = 16'd5208;
	localparam logic [CX_W-1:0]  RST_CENTER_Y = 16'd4056;
	localparam logic [IF_W-1:0]  RST_INV_FX   = 24'd32388;
	localparam logic [IF_W-1:0]  RST_INV_FY   = 24'd32326;
	localparam logic [ROW_W-1:0] RST_ROW0     = 54'd65536;
	localparam logic [ROW_W-1:0] RST_ROW1     = 54'd17179869184;
	localparam logic [ROW_W-1:0] RST_ROW2     = 54'd4503599627370496;
	localparam logic [TR_W-1:0]  RST_TRANS    = '0;

	// load enables of the stages that live inside the rotation row unit
	typedef struct packed {
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
	} dpw_adv_t;

endpackage

FILE: rtl/dpw_row.sv
// One row of the rigid transform: three products, rounded sum, translation
// and saturation over stages 5 to 7. Depends on dpw_pkg.
module dpw_row (
	input  logic                                 clk,
	input  dpw_pkg::dpw_adv_t                    adv,
	input  logic [dpw_pkg::ROW_W-1:0]            coef,
	input  logic signed [dpw_pkg::TRANS_W-1:0]   trans,
	input  logic signed [dpw_pkg::CAM_W-1:0]     cam_x,
	input  logic signed [dpw_pkg::CAM_W-1:0]     cam_y,
	input  logic signed [dpw_pkg::CAM_W-1:0]     cam_z,
	output logic signed [dpw_pkg::OUT_W-1:0]     world
);

	logic signed [dpw_pkg::COEF_W-1:0] c0, c1, c2;
	logic signed [dpw_pkg::PROD_W-1:0] p0_s5, p1_s5, p2_s5;
	logic signed [dpw_pkg::ACC_W-1:0]  acc_s6;
	logic signed [dpw_pkg::WIDE_W-1:0] wide;
	logic signed [dpw_pkg::OUT_W-1:0]  world_s7;

	assign c0 = $signed(coef[dpw_pkg::COEF_W-1:0]);
	assign c1 = $signed(coef[2*dpw_pkg::COEF_W-1:dpw_pkg::COEF_W]);
	assign c2 = $signed(coef[3*dpw_pkg::COEF_W-1:2*dpw_pkg::COEF_W]);

	// floor of (acc + half) / 2^16, then offset
	assign wide = dpw_pkg::WIDE_W'($signed(acc_s6[dpw_pkg::ACC_W-1:16]))
		+ dpw_pkg::WIDE_W'(trans);

	always_ff @(posedge clk) begin
		if (adv.ld_s5) begin
			p0_s5 <= c0 * cam_x;
			p1_s5 <= c1 * cam_y;
			p2_s5 <= c2 * cam_z;
		end
		if (adv.ld_s6) begin
			acc_s6 <= dpw_pkg::ACC_W'(p0_s5) + dpw_pkg::ACC_W'(p1_s5)
				+ dpw_pkg::ACC_W'(p2_s5) + dpw_pkg::RND16;
		end
		if (adv.ld_s7) begin
			if (wide > dpw_pkg::OUT_MAX) begin
				world_s7 <= dpw_pkg::OUT_MAX[dpw_pkg::OUT_W-1:0];
			end else if (wide < dpw_pkg::OUT_MIN) begin
				world_s7 <= dpw_pkg::OUT_MIN[dpw_pkg::OUT_W-1:0];
			end else begin
				world_s7 <= wide[dpw_pkg::OUT_W-1:0];
			end
		end
	end

	assign world = world_s7;

endmodule

FILE: rtl/depth_pixel_to_world_point.sv
// Top level of the depth pixel back-projection block: configuration registers,
// camera-space stages and the output register. Depends on dpw_pkg, dpw_row
// and assert_macros.svh.
//
// Use: pixels stream in on s_tvalid/s_tready/s_tdata, one transfer per pixel.
// A pixel with zero depth is taken and dropped; every other pixel gives one
// world point with its colour on m_tvalid/m_tready/m_tdata.
// Throughput is one pixel per clock while m_tready does not stall the output.
// A result passes through seven register stages (operand subtract, depth
// multiply, focal multiply, rounding, rotation multiply, row sum, translation
// and saturation), the first loaded at the input transfer and the last being
// the output register.
// Each stage advances when it is empty or the stage after it advances, so a
// stall at m_tready only holds the stages that are full; bubbles left by
// dropped pixels close up and s_tready stays high until every stage is full.
// Reset (arst_n low) empties the pipeline and loads the default intrinsics
// (principal point 325.5/253.5, focal 518/519 pixels) and the identity pose.
// Write configuration with cfg_we/cfg_index/cfg_data only while no pixel is
// in flight; the registers feed the stages directly.
module depth_pixel_to_world_point (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [dpw_pkg::IDX_W-1:0]           cfg_index,
	input  logic [dpw_pkg::CFG_W-1:0]           cfg_data,
	// pixel stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dpw_pkg::IN_TDATA_W-1:0]      s_tdata,  // depth_mm, column, row, blue, green, red
	// world point stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dpw_pkg::OUT_TDATA_W-1:0]     m_tdata   // world_x, world_y, world_z, out_blue, out_green, out_red
);

	localparam int CLR_W = 3 * dpw_pkg::COLOR_W;

	// configuration registers
	logic [dpw_pkg::CX_W-1:0]  center_x_q, center_y_q;
	logic [dpw_pkg::IF_W-1:0]  inv_fx_q, inv_fy_q;
	logic [dpw_pkg::ROW_W-1:0] row0_q, row1_q, row2_q;
	logic [dpw_pkg::TR_W-1:0]  trans_q;

	// stage control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7;
	logic in_vld;
	dpw_pkg::dpw_adv_t adv;

	// input fields
	logic [dpw_pkg::DEPTH_W-1:0] in_depth;
	logic [dpw_pkg::COORD_W-1:0] in_col, in_row;
	logic [CLR_W-1:0]            in_clr;

	// datapath
	logic signed [dpw_pkg::DU_W-1:0]  du_s1, dv_s1;
	logic [dpw_pkg::DEPTH_W-1:0]      d_s1, d_s2, d_s3;
	logic signed [dpw_pkg::DUD_W-1:0] dud_s2, dvd_s2;
	logic signed [dpw_pkg::PRJ_W-1:0] px_s3, py_s3;
	logic signed [dpw_pkg::PRJ_W-1:0] px_rnd, py_rnd;
	logic signed [dpw_pkg::CAM_W-1:0] camx_s4, camy_s4, camz_s4;
	logic [CLR_W-1:0] clr_s1, clr_s2, clr_s3, clr_s4, clr_s5, clr_s6, clr_s7;
	logic signed [dpw_pkg::OUT_W-1:0] wx, wy, wz;

	assign in_depth = s_tdata[dpw_pkg::DEPTH_W-1:0];
	assign in_col   = s_tdata[dpw_pkg::IN_COL_LO +: dpw_pkg::COORD_W];
	assign in_row   = s_tdata[dpw_pkg::IN_ROW_LO +: dpw_pkg::COORD_W];
	assign in_clr   = s_tdata[dpw_pkg::IN_CLR_LO +: CLR_W];

	// Configuration decode; bits above a register's width are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= dpw_pkg::RST_CENTER_X;
			center_y_q <= dpw_pkg::RST_CENTER_Y;
			inv_fx_q   <= dpw_pkg::RST_INV_FX;
			inv_fy_q   <= dpw_pkg::RST_INV_FY;
			row0_q     <= dpw_pkg::RST_ROW0;
			row1_q     <= dpw_pkg::RST_ROW1;
			row2_q     <= dpw_pkg::RST_ROW2;
			trans_q    <= dpw_pkg::RST_TRANS;
		end else if (cfg_we) begin
			unique case (dpw_pkg::dpw_reg_t'(cfg_index))
				dpw_pkg::REG_CENTER_X:    center_x_q <= cfg_data[dpw_pkg::CX_W-1:0];
				dpw_pkg::REG_CENTER_Y:    center_y_q <= cfg_data[dpw_pkg::CX_W-1:0];
				dpw_pkg::REG_INV_FOCAL_X: inv_fx_q   <= cfg_data[dpw_pkg::IF_W-1:0];
				dpw_pkg::REG_INV_FOCAL_Y: inv_fy_q   <= cfg_data[dpw_pkg::IF_W-1:0];
				dpw_pkg::REG_ROT_ROW0:    row0_q     <= cfg_data[dpw_pkg::ROW_W-1:0];
				dpw_pkg::REG_ROT_ROW1:    row1_q     <= cfg_data[dpw_pkg::ROW_W-1:0];
				dpw_pkg::REG_ROT_ROW2:    row2_q     <= cfg_data[dpw_pkg::ROW_W-1:0];
				dpw_pkg::REG_TRANSLATION: trans_q    <= cfg_data[dpw_pkg::TR_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances.
	assign ld_s7 = !vld_s7 || m_tready;
	assign ld_s6 = !vld_s6 || ld_s7;
	assign ld_s5 = !vld_s5 || ld_s6;
	assign ld_s4 = !vld_s4 || ld_s5;
	assign ld_s3 = !vld_s3 || ld_s4;
	assign ld_s2 = !vld_s2 || ld_s3;
	assign ld_s1 = !vld_s1 || ld_s2;
	assign s_tready = ld_s1;

	assign adv.ld_s5 = ld_s5;
	assign adv.ld_s6 = ld_s6;
	assign adv.ld_s7 = ld_s7;

	// drop pixels without a depth measurement right at the input
	assign in_vld = s_tvalid && (in_depth != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= in_vld;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
			if (ld_s4) vld_s4 <= vld_s3;
			if (ld_s5) vld_s5 <= vld_s4;
			if (ld_s6) vld_s6 <= vld_s5;
			if (ld_s7) vld_s7 <= vld_s6;
		end
	end

	// Rounding of the back-projection: floor((p + 2^23) / 2^24).
	assign px_rnd = px_s3 + dpw_pkg::RND24;
	assign py_rnd = py_s3 + dpw_pkg::RND24;

	// Camera-space stages; payload registers carry no reset.
	always_ff @(posedge clk) begin
		// s1: pixel offset from the principal point, 4 fraction bits
		if (ld_s1) begin
			du_s1  <= dpw_pkg::DU_W'($signed({1'b0, in_col, 4'b0000}))
				- dpw_pkg::DU_W'($signed({1'b0, center_x_q}));
			dv_s1  <= dpw_pkg::DU_W'($signed({1'b0, in_row, 4'b0000}))
				- dpw_pkg::DU_W'($signed({1'b0, center_y_q}));
			d_s1   <= in_depth;
			clr_s1 <= in_clr;
		end
		// s2: scale by depth
		if (ld_s2) begin
			dud_s2 <= du_s1 * $signed({1'b0, d_s1});
			dvd_s2 <= dv_s1 * $signed({1'b0, d_s1});
			d_s2   <= d_s1;
			clr_s2 <= clr_s1;
		end
		// s3: scale by reciprocal focal length
		if (ld_s3) begin
			px_s3  <= dud_s2 * $signed({1'b0, inv_fx_q});
			py_s3  <= dvd_s2 * $signed({1'b0, inv_fy_q});
			d_s3   <= d_s2;
			clr_s3 <= clr_s2;
		end
		// s4: round to sixteenth millimetres; z is depth times 16, exact
		if (ld_s4) begin
			camx_s4 <= $signed(px_rnd[dpw_pkg::PRJ_W-1:24]);
			camy_s4 <= $signed(py_rnd[dpw_pkg::PRJ_W-1:24]);
			camz_s4 <= dpw_pkg::CAM_W'($signed({1'b0, d_s3, 4'b0000}));
			clr_s4  <= clr_s3;
		end
		if (ld_s5) clr_s5 <= clr_s4;
		if (ld_s6) clr_s6 <= clr_s5;
		if (ld_s7) clr_s7 <= clr_s6;
	end

	// s5..s7: one rotation row per world axis
	dpw_row u_row_x (
		.clk   (clk),
		.adv   (adv),
		.coef  (row0_q),
		.trans ($signed(trans_q[dpw_pkg::TRANS_W-1:0])),
		.cam_x (camx_s4),
		.cam_y (camy_s4),
		.cam_z (camz_s4),
		.world (wx)
	);

	dpw_row u_row_y (
		.clk   (clk),
		.adv   (adv),
		.coef  (row1_q),
		.trans ($signed(trans_q[2*dpw_pkg::TRANS_W-1:dpw_pkg::TRANS_W])),
		.cam_x (camx_s4),
		.cam_y (camy_s4),
		.cam_z (camz_s4),
		.world (wy)
	);

	dpw_row u_row_z (
		.clk   (clk),
		.adv   (adv),
		.coef  (row2_q),
		.trans ($signed(trans_q[3*dpw_pkg::TRANS_W-1:2*dpw_pkg::TRANS_W])),
		.cam_x (camx_s4),
		.cam_y (camy_s4),
		.cam_z (camz_s4),
		.world (wz)
	);

	assign m_tvalid = vld_s7;
	assign m_tdata  = {{dpw_pkg::OUT_PAD{1'b0}}, clr_s7, wz, wy, wx};

	`include "assert_macros.svh"

	// a dropped pixel never occupies the first stage
	`AST_NEXT(a_zero_dropped, s_tvalid && s_tready && (in_depth == '0), !vld_s1)
	// with the output register empty the whole pipeline can take a pixel
	`AST_IMP(a_ready_when_drained, !m_tvalid, s_tready)
	// input back-pressure only when every stage holds a pixel and the sink stalls
	`AST_IMP(a_stall_only_full, vld_s1 && !ld_s1,
		vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7 && !m_tready)

endmodule

FILE: tb/tb.sv
// Self-checking bench for depth_pixel_to_world_point: streams pixels through the block and
// compares every world point with a predictor of the pinhole back-projection and rigid pose.
// Depends on dpw_pkg and the block RTL only.
`timescale 1ns / 100ps

module tb;
	import dpw_pkg::*;

	// saturation bounds of a world coordinate
	localparam longint SAT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) <<< (OUT_W - 1));
	// cycles from an input transfer to its result, with margin
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
		logic [COLOR_W-1:0]      blue;
		logic [COLOR_W-1:0]      green;
		logic [COLOR_W-1:0]      red;
	} point_t;

	// how a directed pixel is checked
	typedef enum logic [1:0] {
		CHK_NONE,     // no world point may come out
		CHK_GIVEN,    // world point typed into the row
		CHK_PREDICT   // world point from the predictor
	} check_t;

	typedef struct packed {
		logic        is_write;
		dpw_reg_t    reg_idx;
		logic [62:0] value;
		pixel_t      pix;
		check_t      chk;
		point_t      given;
	} step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // depth_mm, column, row, blue, green, red
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // world_x, world_y, world_z, out_blue, out_green, out_red

	// predictor copy of the configuration registers
	logic [CX_W-1:0]  ctr_x;
	logic [CX_W-1:0]  ctr_y;
	logic [IF_W-1:0]  ifx;
	logic [IF_W-1:0]  ify;
	logic [ROW_W-1:0] rot [3];
	logic [TR_W-1:0]  trans;

	point_t pending_points [$];
	step_t  plan [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left   = 0;
	int errors      = 0;
	int n_pixels    = 0;
	int n_zero      = 0;
	int n_points    = 0;
	int n_writes    = 0;

	depth_pixel_to_world_point dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Append a world point to the tail of the expected queue.
	function automatic void expect_point(input point_t w);
		pending_points.insert(pending_points.size(), w);
	endfunction

	// Append a row to the tail of the directed plan.
	function automatic void add_step(input step_t s);
		plan.insert(plan.size(), s);
	endfunction

	// Divide by 2^k, rounding to nearest with ties toward plus infinity.
	// An arithmetic shift floors, so adding half first gives exactly that.
	function automatic longint round_half_up(input longint v, input int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	// Back-project one pixel through the pinhole model, then apply R * p + t with
	// saturation. Returns 0 for a zero-depth pixel, which gives no world point.
	function automatic bit backproject(input pixel_t p, output point_t w);
		longint            cam [3];
		longint            acc;
		longint            sum;
		logic signed [17:0] coef;
		logic signed [20:0] offs;
		logic signed [OUT_W-1:0] world [3];
		w = '0;
		w.blue  = p.blue;
		w.green = p.green;
		w.red   = p.red;
		if (p.depth == 0)
			return 1'b0;
		// column and row carry four fraction bits to line up with the principal point
		cam[0] = round_half_up((longint'(p.column) * 16 - longint'(ctr_x))
			* longint'(p.depth) * longint'(ifx), 24);
		cam[1] = round_half_up((longint'(p.row) * 16 - longint'(ctr_y))
			* longint'(p.depth) * longint'(ify), 24);
		cam[2] = longint'(p.depth) * 16;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) begin
				coef = rot[i][COEF_W*k +: COEF_W];
				acc += coef * cam[k];
			end
			offs = trans[TRANS_W*i +: TRANS_W];
			sum = round_half_up(acc, 16) + offs;
			if (sum > SAT_HI)
				sum = SAT_HI;
			else if (sum < SAT_LO)
				sum = SAT_LO;
			world[i] = OUT_W'(sum);
		end
		w.x = world[0];
		w.y = world[1];
		w.z = world[2];
		return 1'b1;
	endfunction

	function automatic step_t pixel_row(input int d, u, v, b, g, r, input check_t chk,
		input longint gx = 0, input longint gy = 0, input longint gz = 0);
		step_t s;
		s = '0;
		s.pix.depth   = DEPTH_W'(d);
		s.pix.column  = COORD_W'(u);
		s.pix.row     = COORD_W'(v);
		s.pix.blue    = COLOR_W'(b);
		s.pix.green   = COLOR_W'(g);
		s.pix.red     = COLOR_W'(r);
		s.chk         = chk;
		s.given.x     = OUT_W'(gx);
		s.given.y     = OUT_W'(gy);
		s.given.z     = OUT_W'(gz);
		s.given.blue  = COLOR_W'(b);
		s.given.green = COLOR_W'(g);
		s.given.red   = COLOR_W'(r);
		return s;
	endfunction

	function automatic step_t write_row(input dpw_reg_t r, input logic [62:0] value);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.reg_idx  = r;
		s.value    = value;
		return s;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int     pick;
		pick = $urandom_range(99);
		// mostly full-range depths; a share of no-measurement, maximum and tiny ones
		if (pick < 8)
			p.depth = '0;
		else if (pick < 13)
			p.depth = '1;
		else if (pick < 20)
			p.depth = DEPTH_W'($urandom_range(1, 15));
		else
			p.depth = DEPTH_W'($urandom);
		p.column = COORD_W'($urandom);
		p.row    = COORD_W'($urandom);
		p.blue   = COLOR_W'($urandom);
		p.green  = COLOR_W'($urandom);
		p.red    = COLOR_W'($urandom);
		return p;
	endfunction

	// Hold the input side quiet until every world point is in, then let any
	// zero-depth pixels still in the pipeline run out.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle, and mirror it in the predictor.
	// Bits above the register width are dropped by the block and here alike.
	task automatic write_reg(input dpw_reg_t r, input logic [62:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_CENTER_X:    ctr_x  = value[CX_W-1:0];
			REG_CENTER_Y:    ctr_y  = value[CX_W-1:0];
			REG_INV_FOCAL_X: ifx    = value[IF_W-1:0];
			REG_INV_FOCAL_Y: ify    = value[IF_W-1:0];
			REG_ROT_ROW0:    rot[0] = value[ROW_W-1:0];
			REG_ROT_ROW1:    rot[1] = value[ROW_W-1:0];
			REG_ROT_ROW2:    rot[2] = value[ROW_W-1:0];
			REG_TRANSLATION: trans  = value[TR_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	// Offer one pixel, with random idle cycles ahead of it, and log the expected
	// world point once the transfer has happened.
	task automatic send_pixel(input pixel_t p, input check_t chk, input point_t given);
		point_t w;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({p.red, p.green, p.blue, p.row, p.column, p.depth});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_pixels++;
		if (p.depth == 0)
			n_zero++;
		case (chk)
			CHK_GIVEN:   expect_point(given);
			CHK_PREDICT: if (backproject(p, w)) expect_point(w);
			default: ;
		endcase
	endtask

	// New random setting for every register. Upper bits carry junk that the
	// block must drop. Most centre and focal settings look like a real camera,
	// and a few settings of every register are the all-zero and all-one extremes.
	task automatic randomize_setup();
		logic [62:0] value;
		int          style;
		dpw_reg_t    r;
		for (int i = 0; i < 8; i++) begin
			r = dpw_reg_t'(i);
			value = 63'({$urandom, $urandom});
			style = $urandom_range(9);
			if (style == 9)
				value = '1;
			else if (style == 8)
				value = '0;
			else if (style < 6) begin
				case (r)
					REG_CENTER_X, REG_CENTER_Y:
						value[CX_W-1:0] = CX_W'($urandom_range(16 * 4095));
					REG_INV_FOCAL_X, REG_INV_FOCAL_Y:
						value[IF_W-1:0] = IF_W'(32'd16777216 / $urandom_range(100, 4000));
					default: ;
				endcase
			end
			write_reg(r, value);
		end
	endtask

	// Output side: random back-pressure, plus a long hold-off when asked for.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Check every output transfer against the oldest pending world point.
	always @(posedge clk) begin : monitor
		point_t got;
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x     = m_tdata[0 +: OUT_W];
			got.y     = m_tdata[OUT_W +: OUT_W];
			got.z     = m_tdata[2*OUT_W +: OUT_W];
			got.blue  = m_tdata[3*OUT_W +: COLOR_W];
			got.green = m_tdata[3*OUT_W + COLOR_W +: COLOR_W];
			got.red   = m_tdata[3*OUT_W + 2*COLOR_W +: COLOR_W];
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected world point, expected none, actual x=%0d y=%0d z=%0d",
					$time, got.x, got.y, got.z);
				errors++;
			end else begin
				want = pending_points.pop_front();
				compare_field("world_x", want.x, got.x);
				compare_field("world_y", want.y, got.y);
				compare_field("world_z", want.z, got.z);
				compare_field("out_blue", want.blue, got.blue);
				compare_field("out_green", want.green, got.green);
				compare_field("out_red", want.red, got.red);
				n_points++;
			end
		end
	end

	// Hard stop for a hung handshake.
	initial begin
		#20_000_000;
		$display("%0t: timeout with %0d world points outstanding", $time, pending_points.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_CENTER_X;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;

		// predictor starts from the reset setting: default intrinsics, identity pose
		ctr_x  = RST_CENTER_X;
		ctr_y  = RST_CENTER_Y;
		ifx    = RST_INV_FX;
		ify    = RST_INV_FY;
		rot[0] = RST_ROW0;
		rot[1] = RST_ROW1;
		rot[2] = RST_ROW2;
		trans  = RST_TRANS;

		// Directed part. Reset setting first: a zero-depth pixel is dropped, and
		// a pixel one millimetre out on the principal ray lands at z = 16.
		add_step(pixel_row(0, 4095, 4095, 8'hFF, 8'hFF, 8'hFF, CHK_NONE));
		add_step(pixel_row(1, 326, 254, 8'h00, 8'h55, 8'hAA, CHK_GIVEN, 0, 0, 16));
		add_step(pixel_row(65535, 0, 0, 8'hFF, 8'h00, 8'hFF, CHK_PREDICT));
		add_step(pixel_row(65535, 4095, 4095, 8'h00, 8'hFF, 8'h00, CHK_PREDICT));
		add_step(pixel_row(1000, 640, 480, 8'h12, 8'h34, 8'h56, CHK_PREDICT));
		// principal point at the origin, unit focal reciprocal: far corner saturates
		// high; junk above the register width must be ignored
		add_step(write_row(REG_CENTER_X, 63'h7FFF_FFFF_FFFF_0000));
		add_step(write_row(REG_CENTER_Y, 63'h7FFF_FFFF_FFFF_0000));
		add_step(write_row(REG_INV_FOCAL_X, 63'h7FFF_FFFF_FFFF_FFFF));
		add_step(write_row(REG_INV_FOCAL_Y, 63'h0000_0000_00FF_FFFF));
		add_step(pixel_row(65535, 4095, 4095, 8'h12, 8'h34, 8'h56, CHK_GIVEN,
			SAT_HI, SAT_HI, 1048560));
		add_step(pixel_row(1, 0, 0, 8'h80, 8'h01, 8'h7F, CHK_GIVEN, 0, 0, 16));
		// principal point at its maximum: the origin pixel saturates low
		add_step(write_row(REG_CENTER_X, 63'h0000_0000_0000_FFFF));
		add_step(write_row(REG_CENTER_Y, 63'h0000_0000_0000_FFFF));
		add_step(pixel_row(65535, 0, 0, 8'h01, 8'h02, 8'h04, CHK_GIVEN,
			SAT_LO, SAT_LO, 1048560));
		add_step(pixel_row(0, 0, 0, 8'h00, 8'h00, 8'h00, CHK_NONE));
		// extreme pose: largest and most negative coefficients, translation limits
		add_step(write_row(REG_CENTER_X, 63'd5208));
		add_step(write_row(REG_CENTER_Y, 63'd4056));
		add_step(write_row(REG_INV_FOCAL_X, 63'd32388));
		add_step(write_row(REG_INV_FOCAL_Y, 63'd32326));
		add_step(write_row(REG_ROT_ROW0, {9'h0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF}));
		add_step(write_row(REG_ROT_ROW1, {9'h0, 18'h20000, 18'h20000, 18'h20000}));
		add_step(write_row(REG_ROT_ROW2, {9'h0, 18'h1FFFF, 18'h20000, 18'h00000}));
		add_step(write_row(REG_TRANSLATION, {21'h0FFFFF, 21'h100000, 21'h0FFFFF}));
		add_step(pixel_row(1, 326, 254, 8'h11, 8'h22, 8'h33, CHK_PREDICT));
		add_step(pixel_row(65535, 0, 4095, 8'h44, 8'h55, 8'h66, CHK_PREDICT));
		add_step(pixel_row(65535, 4095, 0, 8'h77, 8'h88, 8'h99, CHK_PREDICT));
		add_step(pixel_row(4000, 100, 3000, 8'hAA, 8'hBB, 8'hCC, CHK_PREDICT));
		add_step(pixel_row(65535, 4095, 4095, 8'hDD, 8'hEE, 8'hFF, CHK_PREDICT));
		// back to the identity rotation with the most negative translation
		add_step(write_row(REG_ROT_ROW0, RST_ROW0));
		add_step(write_row(REG_ROT_ROW1, RST_ROW1));
		add_step(write_row(REG_ROT_ROW2, RST_ROW2));
		add_step(write_row(REG_TRANSLATION, {21'h100000, 21'h100000, 21'h100000}));
		add_step(pixel_row(1, 326, 254, 8'h5A, 8'hA5, 8'h3C, CHK_PREDICT));
		add_step(pixel_row(65535, 2048, 2048, 8'hC3, 8'h0F, 8'hF0, CHK_PREDICT));
		add_step(pixel_row(0, 2048, 2048, 8'hC3, 8'h0F, 8'hF0, CHK_NONE));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_reg(plan[i].reg_idx, plan[i].value);
			else
				send_pixel(plan[i].pix, plan[i].chk, plan[i].given);
		end

		// Random part: six settings, cycling through receiver-heavy idling,
		// sender-heavy idling and full rate.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin
					tx_idle_pct = 13;
					rx_idle_pct = 83;
				end
				1: begin
					tx_idle_pct = 83;
					rx_idle_pct = 13;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			randomize_setup();
			for (int n = 0; n < 160; n++) begin
				// stall the output long enough to fill the pipeline and drop s_tready
				if (ph == 2 && n == 10)
					hold_left = 300;
				// pause the input until every world point has drained
				if (n == 80)
					settle();
				send_pixel(random_pixel(), CHK_PREDICT, '0);
			end
		end

		settle();
		$display("Run covered %0d pixels (%0d with zero depth) under %0d register writes,",
			n_pixels, n_zero, n_writes);
		$display("with %0d world points compared through idle, stall and full-rate traffic.",
			n_points);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dpw_pkg.sv
rtl/dpw_row.sv
rtl/depth_pixel_to_world_point.sv
tb/tb.sv
